/* rtl/core/loi_pkg.sv */
`default_nettype none

package loi_pkg;

  localparam int LEN_W_DEF    = 16;
  localparam int OFFSET_W_DEF = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAR_WIDTH      = 2'd0,
    REG_CHAR_BYTE_INDEX = 2'd1,
    REG_TAB_STOP_LOG2   = 2'd2,
    REG_START_OFFSET    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } in_item_t;

endpackage

`default_nettype wire

/* rtl/core/loi_in_stage.sv */
`default_nettype none

module loi_in_stage
  import loi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tlast,
  output logic                       item_valid,
  output in_item_t                   item,
  input  wire logic                  item_ready
);

  logic     valid_r;
  in_item_t item_r;

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (item_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte <= in_tdata[7:0];
      item_r.last_byte <= in_tlast;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/loi_core.sv */
`default_nettype none

module loi_core
  import loi_pkg::*;
#(
  parameter int LEN_W       = LEN_W_DEF,
  parameter int OFFSET_W    = OFFSET_W_DEF,
  parameter int OUT_TDATA_W = ((OFFSET_W + 2 * LEN_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  input  in_item_t                    item,
  output logic                        item_ready,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  logic [2:0]          cw_r;
  logic [1:0]          cbi_r;
  logic [2:0]          tsl_r;
  logic [OFFSET_W-1:0] pos_r;
  logic [OFFSET_W-1:0] ls_r;
  logic [LEN_W-1:0]    col_r;
  logic [LEN_W-1:0]    max_r;
  logic                sat_r;
  logic [1:0]          ucnt_r;
  logic [7:0]          uval_r;
  logic                uoz_r;

  logic                out_valid_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [LEN_W-1:0]    out_max_r;
  logic                out_too_r;
  logic                out_fake_r;

  logic                adv;
  logic [2:0]          uw;
  logic                is_char;
  logic [7:0]          val_nxt;
  logic                oz_nxt;
  logic                done;
  logic                lf;
  logic                tab;
  logic [LEN_W:0]      stop;
  logic [LEN_W:0]      inc;
  logic [LEN_W:0]      sum;
  logic [LEN_W-1:0]    col_after;
  logic                sat_after;
  logic [OFFSET_W-1:0] pos_nxt;
  logic                emit_fake;
  logic                emit;
  logic [LEN_W-1:0]    max_nxt;
  logic [LEN_W-1:0]    col_nxt;
  logic [OFFSET_W-1:0] ls_nxt;

  assign item_ready = !out_valid_r || out_tready;
  assign adv        = item_valid && item_ready;

  always_comb begin
    if (cw_r >= 3'd4) begin
      uw = 3'd4;
    end else if (cw_r >= 3'd2) begin
      uw = 3'd2;
    end else begin
      uw = 3'd1;
    end
    is_char = (ucnt_r == cbi_r);
    val_nxt = is_char ? item.data_byte : uval_r;
    oz_nxt  = is_char ? uoz_r : (uoz_r && (item.data_byte == CH_NUL));
    done    = (({1'b0, ucnt_r} + 3'd1) >= uw);
    lf      = done && oz_nxt && (val_nxt == CH_LF);
    tab     = done && oz_nxt && (val_nxt == CH_TAB);

    stop = (LEN_W + 1)'(1) << tsl_r;
    if (tab) begin
      inc = stop - ({1'b0, col_r} & (stop - (LEN_W + 1)'(1)));
    end else begin
      inc = (LEN_W + 1)'(1);
    end
    sum = {1'b0, col_r} + inc;

    col_after = col_r;
    sat_after = sat_r;
    if (done && !lf) begin
      if (sum >= {1'b0, LEN_MAX}) begin
        col_after = LEN_MAX;
        sat_after = 1'b1;
      end else begin
        col_after = sum[LEN_W-1:0];
      end
    end

    pos_nxt   = pos_r + OFFSET_W'(1);
    emit_fake = item.last_byte && !lf && (ls_r != pos_nxt);
    emit      = lf || emit_fake;
    max_nxt   = (emit && (col_after > max_r)) ? col_after : max_r;
    col_nxt   = (lf || item.last_byte) ? '0 : col_after;
    ls_nxt    = (lf || item.last_byte) ? pos_nxt : ls_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r   <= 3'd1;
      cbi_r  <= 2'd0;
      tsl_r  <= 3'd3;
      pos_r  <= '0;
      ls_r   <= '0;
      col_r  <= '0;
      max_r  <= '0;
      sat_r  <= 1'b0;
      ucnt_r <= 2'd0;
      uval_r <= 8'd0;
      uoz_r  <= 1'b1;
    end else if (adv) begin
      pos_r <= pos_nxt;
      ls_r  <= ls_nxt;
      col_r <= col_nxt;
      max_r <= max_nxt;
      sat_r <= sat_after;
      if (done || item.last_byte) begin
        ucnt_r <= 2'd0;
        uval_r <= 8'd0;
        uoz_r  <= 1'b1;
      end else begin
        ucnt_r <= ucnt_r + 2'd1;
        uval_r <= val_nxt;
        uoz_r  <= oz_nxt;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHAR_WIDTH:      cw_r  <= cfg_data[2:0];
        REG_CHAR_BYTE_INDEX: cbi_r <= cfg_data[1:0];
        REG_TAB_STOP_LOG2:   tsl_r <= cfg_data[2:0];
        REG_START_OFFSET: begin
          pos_r <= OFFSET_W'(cfg_data);
          ls_r  <= OFFSET_W'(cfg_data);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_off_r  <= lf ? pos_nxt : (pos_nxt + OFFSET_W'(1));
      out_len_r  <= col_after;
      out_max_r  <= max_nxt;
      out_too_r  <= sat_after;
      out_fake_r <= emit_fake;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_max_r, out_len_r, out_off_r});
  assign out_tuser  = {out_fake_r, out_too_r};

endmodule

`default_nettype wire

/* rtl/core/line_offset_indexer_tab_expand.sv */
// Line offset indexer with tab expansion.
// The slave stream carries one byte of a text file per word in in_tdata, with
// in_tlast marking the final byte of the file. Bytes are grouped into code
// units of 1, 2 or 4 bytes; the column advances per unit and tabs expand to
// the next tab stop. Each line feed unit, and an unterminated final line at
// in_tlast, produces one word on the master stream with the next line offset,
// the line length and the running maximum length.
// The configuration port writes the unit width, the character byte index,
// the tab stop and the start offset; the user must write it only while the
// block is idle, which the block does not enforce; writing the start offset
// also restarts the byte counters. A byte accepted into the input register
// is processed from there into the output register when that register can
// take it. One byte per cycle is sustained while the receiver accepts words;
// the column and offset update path is combinational.
// When the receiver stalls, the output register holds its word and the input
// register holds one more byte before in_tready drops. Synchronous reset
// restores the register defaults, clears the counters and empties both stages.
`default_nettype none

module line_offset_indexer_tab_expand
  import loi_pkg::*;
#(
  parameter int LEN_W       = LEN_W_DEF,
  parameter int OFFSET_W    = OFFSET_W_DEF,
  parameter int OUT_TDATA_W = ((OFFSET_W + 2 * LEN_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: data_byte.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: next_line_offset, line_length, max_line_len, zero fill.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Fields from bit 0: too_long, fake_final.
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  logic     item_valid;
  in_item_t item;
  logic     item_ready;

  loi_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  loi_core #(
    .LEN_W       (LEN_W),
    .OFFSET_W    (OFFSET_W),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
  import loi_pkg::*;

  localparam int OUT_W      = ((OFFSET_W_DEF + 2 * LEN_W_DEF + 7) / 8) * 8;
  localparam int LIMIT      = 400000;
  localparam int SETTLE_CYC = 8;
  localparam int RAND_BYTES = 1450;

  typedef struct packed {
    logic [39:0] offs;
    logic [15:0] len;
    logic [15:0] maxl;
    logic        too_long;
    logic        fake;
  } line_rec_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_LINE} row_kind_t;
  typedef enum logic [2:0] {U_PLAIN, U_TAB, U_LF, U_NEAR, U_RAW} unit_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [39:0] val;
    logic [7:0]  data;
    logic        fin;
    line_rec_t   want;
  } drow_t;

  localparam line_rec_t NO_LINE = '0;
  localparam int N_DIR = 31;
  localparam drow_t DIR_TAB [N_DIR] = '{
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, 8'h61, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_TAB, 1'b0, NO_LINE},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0, '{40'd3, 16'd8, 16'd8, 1'b0, 1'b0}},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0, '{40'd4, 16'd0, 16'd8, 1'b0, 1'b0}},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, 8'hFF, 1'b1, '{40'd6, 16'd1, 16'd8, 1'b0, 1'b1}},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b1, '{40'd6, 16'd0, 16'd8, 1'b0, 1'b0}},
    '{ROW_CFG, REG_CHAR_WIDTH, 40'd2, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_CHAR_BYTE_INDEX, 40'd1, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_TAB_STOP_LOG2, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_START_OFFSET, 40'hFF_FFFF_FFFC, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0,
      '{40'hFF_FFFF_FFFE, 16'd0, 16'd8, 1'b0, 1'b0}},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_TAB, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, 8'h01, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0, NO_LINE},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b1, '{40'd6, 16'd3, 16'd8, 1'b0, 1'b1}},
    '{ROW_CFG, REG_CHAR_WIDTH, 40'd5, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_CHAR_BYTE_INDEX, 40'd3, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_TAB_STOP_LOG2, 40'd7, CH_NUL, 1'b0, NO_LINE},
    '{ROW_CFG, REG_START_OFFSET, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_TAB, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_BYTE, REG_CHAR_WIDTH, 40'd0, CH_NUL, 1'b0, NO_LINE},
    '{ROW_LINE, REG_CHAR_WIDTH, 40'd0, CH_LF, 1'b0, '{40'd8, 16'd128, 16'd128, 1'b0, 1'b0}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_reg_t             cfg_index = REG_CHAR_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  line_offset_indexer_tab_expand u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, mirroring the block's registers and counters.
  logic [2:0]  width_reg = 3'd1;
  logic [1:0]  cidx_reg  = 2'd0;
  logic [2:0]  tabl2_reg = 3'd3;
  logic [39:0] pos_q     = '0;
  logic [39:0] lstart_q  = '0;
  logic [15:0] col_q     = '0;
  logic [15:0] longest_q = '0;
  logic        sat_q     = 1'b0;
  logic [1:0]  ucnt_q    = '0;
  logic [7:0]  uchar_q   = '0;
  logic        uclean_q  = 1'b1;

  line_rec_t   line_q[$];
  logic [8:0]  stream[$];
  int          errors = 0;
  int          sent = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic int unsigned unit_w();
    return (width_reg >= 3'd4) ? 4 : (width_reg >= 3'd2) ? 2 : 1;
  endfunction

  function automatic line_rec_t close_line(input logic [39:0] offs, input logic fake);
    if (col_q > longest_q) longest_q = col_q;
    return '{offs, col_q, longest_q, sat_q, fake};
  endfunction

  function automatic bit index_byte(input logic [7:0] b, input logic fin,
                                    output line_rec_t r);
    int unsigned w;
    int unsigned stop;
    int unsigned nc;
    bit got;
    bit is_lf;
    bit is_tab;
    got = 1'b0;
    r = '0;
    w = unit_w();
    pos_q = pos_q + 40'd1;
    if (ucnt_q == cidx_reg) uchar_q = b;
    else if (b != 8'd0) uclean_q = 1'b0;
    if (ucnt_q + 1 >= w) begin
      is_lf  = uclean_q && uchar_q == CH_LF;
      is_tab = uclean_q && uchar_q == CH_TAB;
      ucnt_q = '0;
      uchar_q = '0;
      uclean_q = 1'b1;
      if (is_lf) begin
        r = close_line(pos_q, 1'b0);
        got = 1'b1;
        lstart_q = pos_q;
        col_q = '0;
      end else begin
        stop = 1 << tabl2_reg;
        nc = is_tab ? col_q + stop - (col_q & (stop - 1)) : col_q + 1;
        if (nc >= 65535) begin
          col_q = 16'hFFFF;
          sat_q = 1'b1;
        end else begin
          col_q = 16'(nc);
        end
      end
    end else begin
      ucnt_q = ucnt_q + 2'd1;
    end
    if (fin) begin
      if (!got && lstart_q != pos_q) begin
        r = close_line(pos_q + 40'd1, 1'b1);
        got = 1'b1;
      end
      ucnt_q = '0;
      uchar_q = '0;
      uclean_q = 1'b1;
      col_q = '0;
      lstart_q = pos_q;
    end
    return got;
  endfunction

  function automatic void add_unit(input unit_kind_t k);
    int unsigned w;
    int unsigned spoil;
    logic [7:0] ch;
    w = unit_w();
    if (k == U_RAW) begin
      stream.push_back({1'b0, 8'($urandom)});
      return;
    end
    case (k)
      U_LF:    ch = CH_LF;
      U_TAB:   ch = CH_TAB;
      U_NEAR:  ch = $urandom_range(0, 1) ? CH_LF : CH_TAB;
      default: ch = 8'($urandom);
    endcase
    spoil = (k == U_NEAR && w > 1) ? $urandom_range(0, w - 1) : w;
    for (int j = 0; j < w; j++) begin
      if (j == cidx_reg) stream.push_back({1'b0, ch});
      else if (j == spoil) stream.push_back({1'b0, 8'($urandom_range(1, 255))});
      else stream.push_back({1'b0, CH_NUL});
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [39:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      REG_CHAR_WIDTH:      width_reg = v[2:0];
      REG_CHAR_BYTE_INDEX: cidx_reg = v[1:0];
      REG_TAB_STOP_LOG2:   tabl2_reg = v[2:0];
      REG_START_OFFSET: begin
        pos_q = v;
        lstart_q = v;
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input line_rec_t want);
    line_rec_t r;
    cfg_we <= 1'b0;
    calm = (sent >= 300 && sent < 650);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    if (index_byte(b, fin, r)) line_q.push_back(typed ? want : r);
    else if (typed) line_q.push_back(want);
    sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    line_rec_t got;
    line_rec_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[39:0], out_tdata[55:40], out_tdata[71:56],
                out_tuser[0], out_tuser[1]};
        if (line_q.size() == 0) begin
          report_mismatch("unexpected word, next_line_offset", got.offs, '0);
        end else begin
          want = line_q.pop_front();
          if (got.offs != want.offs) report_mismatch("next_line_offset", got.offs, want.offs);
          if (got.len != want.len) report_mismatch("line_length", got.len, want.len);
          if (got.maxl != want.maxl) report_mismatch("max_line_len", got.maxl, want.maxl);
          if (got.too_long != want.too_long)
            report_mismatch("too_long", got.too_long, want.too_long);
          if (got.fake != want.fake) report_mismatch("fake_final", got.fake, want.fake);
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    int base;
    int nlines;
    int nunits;
    int pick;
    bit sat_done;
    logic [2:0] cw;
    logic [1:0] ci;
    logic [39:0] so;
    sat_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (i > 0 && DIR_TAB[i-1].kind != ROW_CFG) settle();
        write_reg(DIR_TAB[i].sel, DIR_TAB[i].val);
      end else begin
        push_byte(DIR_TAB[i].data, DIR_TAB[i].fin, DIR_TAB[i].kind == ROW_LINE,
                  DIR_TAB[i].want);
      end
    end

    base = sent;
    while (sent - base < RAND_BYTES) begin
      settle();
      if (!sat_done && sent - base >= 800) begin
        // One very long line of wide tabs drives the column into saturation.
        write_reg(REG_CHAR_WIDTH, 40'd1);
        write_reg(REG_CHAR_BYTE_INDEX, 40'd0);
        write_reg(REG_TAB_STOP_LOG2, 40'd7);
        repeat (520) stream.push_back({1'b0, CH_TAB});
        stream.push_back({1'b0, CH_LF});
        add_unit(U_PLAIN);
        stream[$][8] = 1'b1;
        sat_done = 1'b1;
      end else begin
        cw = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'(1 << $urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) write_reg(REG_CHAR_WIDTH, {37'd0, cw});
        ci = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(0, unit_w() - 1));
        if ($urandom_range(0, 3) != 0) write_reg(REG_CHAR_BYTE_INDEX, {38'd0, ci});
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_TAB_STOP_LOG2, 40'($urandom_range(0, 7)));
        pick = $urandom_range(0, 4);
        if (pick != 4) begin
          case (pick)
            0:       so = '0;
            1:       so = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 40));
            default: so = {8'($urandom), 32'($urandom)};
          endcase
          write_reg(REG_START_OFFSET, so);
        end
        nlines = $urandom_range(1, 6);
        for (int ln = 0; ln < nlines; ln++) begin
          nunits = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
          repeat (nunits) begin
            pick = $urandom_range(0, 99);
            add_unit(pick < 20 ? U_TAB : pick < 30 ? U_NEAR : pick < 35 ? U_RAW : U_PLAIN);
          end
          if (ln < nlines - 1 || $urandom_range(0, 3) != 0) add_unit(U_LF);
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) stream.push_back({1'b0, 8'($urandom)});
        if ($urandom_range(0, 9) == 0 && stream.size() != 0)
          stream[$urandom_range(0, stream.size() - 1)][8] = 1'b1;
        if ($urandom_range(0, 2) != 0 && stream.size() != 0) stream[$][8] = 1'b1;
      end
      foreach (stream[k]) push_byte(stream[k][7:0], stream[k][8], 1'b0, NO_LINE);
      stream.delete();
    end

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
